>>> hw/rtl/sefc_pkg.sv
// Shared types, constants and helper functions for the STX/ETX frame checker.
`default_nettype none

package sefc_pkg;

  localparam int unsigned MaxFrameLenDefault = 256;
  localparam int unsigned MinFrameLen        = 7;
  localparam int unsigned NumCmds            = 22;
  localparam int unsigned OqDepth            = 4;

  localparam logic [7:0] StxChar = 8'h02;
  localparam logic [7:0] EtxChar = 8'h03;

  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBadDelim = 3'd1;
  localparam logic [2:0] StatusBadSum   = 3'd2;
  localparam logic [2:0] StatusBadCmd   = 3'd3;
  localparam logic [2:0] StatusBadLen   = 3'd4;

  typedef logic [23:0] cmd_t;

  localparam cmd_t CmdTable [NumCmds] = '{
    "AMS", "AMF", "IR*", "OCV", "IDN", "SIZ", "STP", "FIN", "MAN", "SEN", "OUT",
    "BCR", "EMS", "RST", "REM", "ERR", "CLR", "REC", "LRM", "FRM", "STA", "DEV"
  };

  typedef struct packed {
    logic       verdict_last;
    logic [7:0] param_byte;
    logic [2:0] frame_status;
    logic [4:0] command_code;
    logic [7:0] param_count;
  } result_t;

  // Up to two result items produced by one byte, first item in a.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    a;
    result_t    b;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } cmd_hit_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + wide;
    end else begin
      return 8'h41 + wide - 8'd10;
    end
  endfunction

  // Compare against every table entry in parallel; lowest index wins.
  function automatic cmd_hit_t cmd_lookup(input cmd_t chars);
    cmd_hit_t res;
    res = '0;
    for (int i = NumCmds - 1; i >= 0; i--) begin
      if (CmdTable[i] == chars) begin
        res.hit  = 1'b1;
        res.code = 5'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sefc_core.sv
// Input register and per-byte frame tracking: parameter extraction and verdict.
`default_nettype none

module sefc_core #(
  parameter int unsigned MAX_FRAME_LEN = sefc_pkg::MaxFrameLenDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            end_of_message,
  input  wire logic            space_ok,
  output      sefc_pkg::push_t push
);
  import sefc_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_LEN);

  logic            stg_valid_r;
  logic [7:0]      stg_byte_r;
  logic            stg_eom_r;
  logic            fire;

  logic [PosW-1:0] pos_r,   pos_nxt;
  logic [7:0]      sum_r,   sum_nxt;
  logic [7:0]      first_r, first_nxt;
  cmd_t            cmd_r,   cmd_nxt;
  logic [7:0]      dly_r [3];
  logic [7:0]      cnt_r,   cnt_nxt;

  logic            emit;
  logic [7:0]      leaving;
  logic [2:0]      status;
  logic [4:0]      code;
  cmd_hit_t        lookup;
  result_t         param_item;
  result_t         verdict_item;

  assign fire     = stg_valid_r && space_ok;
  assign in_ready = !stg_valid_r || fire;

  // Hold the accepted byte until the result queue has room for two items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte_r <= rx_byte;
      stg_eom_r  <= end_of_message;
    end
  end

  always_comb begin
    leaving   = dly_r[2];
    sum_nxt   = (pos_r >= PosW'(4)) ? sum_r + leaving : sum_r;
    emit      = (pos_r >= PosW'(MinFrameLen)) && (pos_r < MaxPos);
    cnt_nxt   = emit ? cnt_r + 8'd1 : cnt_r;
    first_nxt = (pos_r == '0) ? stg_byte_r : first_r;
    cmd_nxt   = ((pos_r != '0) && (pos_r <= PosW'(3))) ? {cmd_r[15:0], stg_byte_r} : cmd_r;
    pos_nxt   = (pos_r == MaxPos) ? pos_r : pos_r + PosW'(1);
    lookup    = cmd_lookup(cmd_nxt);

    code = '0;
    if ((pos_r < PosW'(MinFrameLen - 1)) || (pos_r == MaxPos)) begin
      status = StatusBadLen;
    end else if ((first_nxt != StxChar) || (stg_byte_r != EtxChar)) begin
      status = StatusBadDelim;
    end else if ((dly_r[1] != hex_char(sum_nxt[7:4])) ||
                 (dly_r[0] != hex_char(sum_nxt[3:0]))) begin
      status = StatusBadSum;
    end else if (!lookup.hit) begin
      status = StatusBadCmd;
    end else begin
      status = StatusOk;
      code   = lookup.code;
    end

    param_item              = '0;
    param_item.param_byte   = leaving;
    verdict_item              = '0;
    verdict_item.verdict_last = 1'b1;
    verdict_item.frame_status = status;
    verdict_item.command_code = code;
    verdict_item.param_count  = cnt_nxt;

    push.cnt = fire ? ({1'b0, emit} + {1'b0, stg_eom_r}) : 2'd0;
    push.a   = emit ? param_item : verdict_item;
    push.b   = verdict_item;
  end

  // Advance frame state; clear everything after the verdict.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      first_r <= '0;
      cmd_r   <= '0;
      cnt_r   <= '0;
      dly_r   <= '{default: '0};
    end else if (fire) begin
      if (stg_eom_r) begin
        pos_r   <= '0;
        sum_r   <= '0;
        first_r <= '0;
        cmd_r   <= '0;
        cnt_r   <= '0;
        dly_r   <= '{default: '0};
      end else begin
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        first_r  <= first_nxt;
        cmd_r    <= cmd_nxt;
        cnt_r    <= cnt_nxt;
        dly_r[0] <= stg_byte_r;
        dly_r[1] <= dly_r[0];
        dly_r[2] <= dly_r[1];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sefc_oq.sv
// Small result queue: takes up to two items per cycle, hands out one per transfer.
`default_nettype none

module sefc_oq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sefc_pkg::push_t   push,
  output      logic              space_ok,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      sefc_pkg::result_t out_item
);
  import sefc_pkg::*;

  localparam int unsigned PtrW = $clog2(OqDepth);
  localparam int unsigned CntW = $clog2(OqDepth + 1);

  result_t         mem_r [OqDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (count_r <= CntW'(OqDepth - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PtrW'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      count_r <= count_r + CntW'(push.cnt) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stx_etx_frame_checker_unit.sv
// Top level of the STX/ETX frame checker: byte input, parameter and verdict output.
// Usage:
//   Feed the received message one byte per transfer on the in_ channel, with
//   in_end_of_message high on the final byte (expected ETX). Each byte that
//   falls out of the three-byte delay line within the first MAX_FRAME_LEN
//   bytes of a frame of at least seven bytes comes back as a parameter item
//   (out_verdict_last low). The final byte yields a verdict item
//   (out_verdict_last high) with status, command code and the count of
//   parameter bytes; it follows any parameter item from that byte.
// Order: a byte is registered in the input stage, written to the result queue
//   once the queue has room, and presented from there; a verdict leaves the
//   queue after its parameter item if both come together.
// Throughput: one input byte per cycle while the queue has room for two items,
//   set by the input stage feeding a four-entry result queue; the queue drains
//   one item per cycle while out_ready is high, so a final byte adds an item.
// Reset (rst_n low, synchronous) empties the stage and queue and clears all
//   frame state, as after a verdict.
// Stall: while out_ready is low, results wait in the queue; once it cannot
//   take two more items the input stage holds and in_ready drops.
`default_nettype none

module stx_etx_frame_checker_unit #(
  parameter int unsigned MAX_FRAME_LEN = sefc_pkg::MaxFrameLenDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_end_of_message,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_verdict_last,
  output      logic [7:0] out_param_byte,
  output      logic [2:0] out_frame_status,
  output      logic [4:0] out_command_code,
  output      logic [7:0] out_param_count
);
  import sefc_pkg::*;

  push_t   push;
  logic    space_ok;
  result_t out_item;

  // Input stage and frame tracking.
  sefc_core #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (in_rx_byte),
    .end_of_message(in_end_of_message),
    .space_ok      (space_ok),
    .push          (push)
  );

  // Result queue parts the output side from the input side.
  sefc_oq u_oq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  assign out_verdict_last = out_item.verdict_last;
  assign out_param_byte   = out_item.param_byte;
  assign out_frame_status = out_item.frame_status;
  assign out_command_code = out_item.command_code;
  assign out_param_count  = out_item.param_count;

endmodule

`default_nettype wire

>>> tb/sv/stx_etx_frame_checker_unit_tb.sv
// Self-checking testbench for the STX/ETX frame checker: random and directed frames, scoreboard.
`default_nettype none

module stx_etx_frame_checker_unit_tb;
  import sefc_pkg::*;

  localparam int FrameLenMax = 256;
  localparam int TargetBytes = 1900;
  localparam int DrainCycles = 16;
  localparam int ReportLimit = 10;

  // Ways a generated frame can be spoiled on purpose.
  typedef enum int {
    FlawNone,
    FlawStx,
    FlawEtx,
    FlawSum,
    FlawLower
  } frame_flaw_t;

  typedef struct {
    logic [7:0] rx;
    logic       eom;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_verdict_last;
  logic [7:0] out_param_byte;
  logic [2:0] out_frame_status;
  logic [4:0] out_command_code;
  logic [7:0] out_param_count;

  stx_etx_frame_checker_unit #(
    .MAX_FRAME_LEN(FrameLenMax)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict_last  (out_verdict_last),
    .out_param_byte    (out_param_byte),
    .out_frame_status  (out_frame_status),
    .out_command_code  (out_command_code),
    .out_param_count   (out_param_count)
  );

  always #10 clk = ~clk;

  // Bytes still to be sent, and result items the frame tracker has predicted.
  rx_item_t tx_bytes[$];
  result_t  frame_results_due[$];

  // Shadow copy of the frame state, updated on every input transfer.
  logic [8:0]  f_pos = '0;
  logic [7:0]  f_sum = '0;
  logic [7:0]  f_first = '0;
  cmd_t        f_cmd = '0;
  logic [7:0]  f_dl [3] = '{8'h00, 8'h00, 8'h00};
  logic [7:0]  f_pcnt = '0;

  int errors = 0;
  int bytes_sent = 0;
  int param_items = 0;
  int verdict_items = 0;
  int status_seen [5] = '{0, 0, 0, 0, 0};
  bit in_took = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int rdy_mode = 0;
  int rdy_left = 0;

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  // Advance the frame tracker by one byte and queue the results it causes.
  task automatic track_frame_byte(input logic [7:0] b, input logic eom);
    logic [8:0] p;
    logic [7:0] leaving;
    result_t    r;
    int         len;
    int         i;
    bit         found;
    p = f_pos;
    leaving = f_dl[2];
    if (p >= 4) f_sum = f_sum + leaving;
    // The byte falling out of the delay line is a parameter while the frame
    // still fits in the maximum length.
    if (p >= MinFrameLen && p <= FrameLenMax - 1) begin
      r = '0;
      r.param_byte = leaving;
      frame_results_due = {frame_results_due, r};
      f_pcnt = f_pcnt + 8'd1;
    end
    if (p == 0) f_first = b;
    else if (p <= 3) f_cmd = {f_cmd[15:0], b};
    if (eom) begin
      r = '0;
      r.verdict_last = 1'b1;
      r.param_count = f_pcnt;
      len = int'(p) + 1;
      if (len < MinFrameLen || len > FrameLenMax) begin
        r.frame_status = StatusBadLen;
      end else if (f_first != StxChar || b != EtxChar) begin
        r.frame_status = StatusBadDelim;
      end else if (f_dl[1] != nibble_ascii(f_sum[7:4]) ||
                   f_dl[0] != nibble_ascii(f_sum[3:0])) begin
        r.frame_status = StatusBadSum;
      end else begin
        found = 1'b0;
        for (i = 0; i < NumCmds; i++) begin
          if (!found && CmdTable[i] == f_cmd) begin
            found = 1'b1;
            r.command_code = 5'(i);
          end
        end
        r.frame_status = found ? StatusOk : StatusBadCmd;
      end
      frame_results_due = {frame_results_due, r};
      // Verdict closes the frame: clear everything.
      f_pos = '0;
      f_sum = '0;
      f_first = '0;
      f_cmd = '0;
      f_dl = '{8'h00, 8'h00, 8'h00};
      f_pcnt = '0;
    end else begin
      f_dl[2] = f_dl[1];
      f_dl[1] = f_dl[0];
      f_dl[0] = b;
      f_pos = (p >= FrameLenMax) ? 9'(FrameLenMax) : p + 9'd1;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eom);
    rx_item_t it;
    it.rx = b;
    it.eom = eom;
    tx_bytes = {tx_bytes, it};
  endtask

  // Build a framed command with random parameters, optionally spoiled.
  task automatic add_frame(input cmd_t cmd, input int nparam, input frame_flaw_t flaw);
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] hi;
    logic [7:0] lo;
    int         i;
    sum = cmd[23:16] + cmd[15:8] + cmd[7:0];
    if (flaw == FlawStx) begin
      pb = 8'($urandom_range(0, 255));
      if (pb == StxChar) pb = 8'hFF;
      queue_byte(pb, 1'b0);
    end else begin
      queue_byte(StxChar, 1'b0);
    end
    queue_byte(cmd[23:16], 1'b0);
    queue_byte(cmd[15:8], 1'b0);
    queue_byte(cmd[7:0], 1'b0);
    for (i = 0; i < nparam; i++) begin
      pb = 8'($urandom_range(0, 255));
      sum = sum + pb;
      queue_byte(pb, 1'b0);
    end
    if (flaw == FlawSum) sum = sum ^ 8'($urandom_range(1, 255));
    hi = nibble_ascii(sum[7:4]);
    lo = nibble_ascii(sum[3:0]);
    // Lowercase letters must never be accepted as checksum digits.
    if (flaw == FlawLower) begin
      if (hi >= 8'h41) hi = hi | 8'h20;
      if (lo >= 8'h41) lo = lo | 8'h20;
    end
    queue_byte(hi, 1'b0);
    queue_byte(lo, 1'b0);
    if (flaw == FlawEtx) begin
      pb = 8'($urandom_range(0, 255));
      if (pb == EtxChar) pb = 8'h83;
      queue_byte(pb, 1'b1);
    end else begin
      queue_byte(EtxChar, 1'b1);
    end
  endtask

  // Unstructured bytes with the end flag on the last one.
  task automatic add_raw(input int len);
    logic [7:0] pb;
    int         i;
    for (i = 0; i < len; i++) begin
      pb = 8'($urandom_range(0, 255));
      if (i == 0 && $urandom_range(0, 1) == 0) pb = StxChar;
      queue_byte(pb, i == len - 1);
    end
  endtask

  // Sample both handshakes at the rising edge; predict on input transfers,
  // check on output transfers.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_frame_byte(in_rx_byte, in_end_of_message);
        in_took = 1'b1;
        bytes_sent++;
      end
      if (out_valid && out_ready) begin
        got.verdict_last = out_verdict_last;
        got.param_byte = out_param_byte;
        got.frame_status = out_frame_status;
        got.command_code = out_command_code;
        got.param_count = out_param_count;
        if (got.verdict_last) begin
          verdict_items++;
          if (got.frame_status <= StatusBadLen) status_seen[got.frame_status]++;
        end else begin
          param_items++;
        end
        if (frame_results_due.size() == 0) begin
          if (errors < ReportLimit)
            $display("unexpected result: last=%0d byte=%02h status=%0d code=%0d count=%0d",
                     got.verdict_last, got.param_byte, got.frame_status,
                     got.command_code, got.param_count);
          errors++;
        end else begin
          want = frame_results_due.pop_front();
          if (got.verdict_last !== want.verdict_last || got.param_byte !== want.param_byte ||
              got.frame_status !== want.frame_status ||
              got.command_code !== want.command_code ||
              got.param_count !== want.param_count) begin
            if (errors < ReportLimit) begin
              $display("mismatch: expected last=%0d byte=%02h status=%0d code=%0d count=%0d",
                       want.verdict_last, want.param_byte, want.frame_status,
                       want.command_code, want.param_count);
              $display("          got      last=%0d byte=%02h status=%0d code=%0d count=%0d",
                       got.verdict_last, got.param_byte, got.frame_status,
                       got.command_code, got.param_count);
            end
            errors++;
          end
        end
      end
    end
  end

  // Byte driver: bursts of transfers separated by random gaps; valid holds
  // with a steady payload until the transfer happens.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (in_took) begin
        in_took = 1'b0;
        tx_bytes.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) :
                                                     $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= tx_bytes[0].rx;
        in_end_of_message <= tx_bytes[0].eom;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: switch between always ready, coin flips and mostly
  // stalled, each for a random stretch of cycles.
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(40, 200);
    end
    rdy_left--;
    case (rdy_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  initial begin
    cmd_t cmd;
    int   frame_idx;
    int   pick;
    // Directed: shortest good frame with the first command, the last command
    // with parameters, a lone end byte, a lowercase checksum, a short frame.
    add_frame(CmdTable[0], 0, FlawNone);
    add_frame(CmdTable[NumCmds - 1], 2, FlawNone);
    add_raw(1);
    add_frame(CmdTable[0], 0, FlawLower);
    add_raw(MinFrameLen - 1);

    frame_idx = 0;
    while (tx_bytes.size() < TargetBytes) begin
      cmd = CmdTable[$urandom_range(0, NumCmds - 1)];
      pick = $urandom_range(0, 99);
      if (frame_idx == 30) begin
        // Frame of exactly the maximum length: largest parameter count.
        add_frame(cmd, FrameLenMax - MinFrameLen, FlawNone);
      end else if (frame_idx == 60) begin
        add_frame(cmd, FrameLenMax - MinFrameLen + 1, FlawNone);
      end else if (pick < 50) begin
        add_frame(cmd, $urandom_range(0, 10), FlawNone);
      end else if (pick < 58) begin
        add_frame(cmd, $urandom_range(0, 6), FlawStx);
      end else if (pick < 64) begin
        add_frame(cmd, $urandom_range(0, 6), FlawEtx);
      end else if (pick < 72) begin
        add_frame(cmd, $urandom_range(0, 6), FlawSum);
      end else if (pick < 78) begin
        add_frame(cmd, $urandom_range(0, 6), FlawLower);
      end else if (pick < 86) begin
        add_frame(cmd_t'($urandom), $urandom_range(0, 6), FlawNone);
      end else if (pick < 93) begin
        add_raw($urandom_range(1, MinFrameLen - 1));
      end else if (pick < 99) begin
        add_raw($urandom_range(MinFrameLen, 24));
      end else begin
        add_frame(cmd, $urandom_range(FrameLenMax - MinFrameLen - 2,
                                      FrameLenMax - MinFrameLen + 6), FlawNone);
      end
      frame_idx++;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (frame_results_due.size() != 0) errors++;

    $display("Sent %0d bytes in %0d frames; checked %0d parameter items and %0d verdicts.",
             bytes_sent, verdict_items, param_items, verdict_items);
    $display("Verdicts ok/delim/sum/cmd/len: %0d/%0d/%0d/%0d/%0d; %0d mismatches.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding.", frame_results_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
